>>> rtl/core/mdu_pkg.sv
// Package for the multiply/divide unit: operation codes, word width and the
// control struct that travels down the divider pipeline.
// No dependencies.
package mdu_pkg;

   localparam int DataWidth = 32;
   localparam int OpWidth   = 3;

   typedef logic [DataWidth-1:0] word_type;
   typedef logic [OpWidth-1:0]   mdu_op_type;

   localparam mdu_op_type OP_MUL  = 3'd0;
   localparam mdu_op_type OP_DIVU = 3'd4;
   localparam mdu_op_type OP_DIV  = 3'd5;
   localparam mdu_op_type OP_REMU = 3'd6;
   localparam mdu_op_type OP_REM  = 3'd7;

   typedef struct packed {
      logic       valid;
      mdu_op_type op;
      logic       quo_neg;
      logic       rem_neg;
   } pipe_ctl_type;

endpackage

>>> rtl/core/multiply_divide_unit_top.sv
// Top level of the multiply/divide unit: operand prep stage, divider
// pipeline of mdu_div_step stages, result select and output/skid registers.
// Depends on mdu_pkg and mdu_div_step.
//
// Usage: the req channel takes one word per cycle (req_type, req_operand_a,
// req_operand_b) when req_valid is high and req_stall low. Code 0 returns the
// low product word, 4/5 unsigned/signed quotient, 6/7 unsigned/signed
// remainder, 1 to 3 return zero. Divide by zero gives all ones (quotient) or
// the dividend (remainder).
// Path: from acceptance to rsp_valid a word passes the prep register, the 32
// one-bit restoring divider stages and the output register; all codes take
// the same path.
// Throughput: one word per cycle while the receiver keeps up.
// Stall: rsp_valid and rsp_result hold while rsp_stall is high. A skid
// register catches the word leaving the pipeline; once it is full, req_stall
// rises and the whole pipeline freezes until the receiver drains it.
// Reset: clears all valid bits; req_stall is low after reset.
module multiply_divide_unit_top import mdu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  mdu_op_type req_type,
   input  word_type   req_operand_a,
   input  word_type   req_operand_b,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output word_type   rsp_result
);

   localparam int Steps = DataWidth;

   pipe_ctl_type ctl_pipe  [0:Steps];
   word_type     rem_pipe  [0:Steps];
   word_type     quo_pipe  [0:Steps];
   word_type     div_pipe  [0:Steps];
   word_type     prod_pipe [0:Steps];

   logic         en;
   logic         push;
   logic         rsp_take;
   logic         skid_valid_ff;
   logic         rsp_valid_ff;
   word_type     skid_result_ff;
   word_type     rsp_result_ff;
   word_type     final_result;

   // prep stage
   logic         signed_op;
   logic         a_neg;
   logic         b_neg;
   pipe_ctl_type prep_ctl_in;
   word_type     abs_a_in;
   word_type     abs_b_in;
   word_type     prod_low;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   always_comb begin
      signed_op           = (req_type == OP_DIV) || (req_type == OP_REM);
      a_neg               = signed_op && req_operand_a[DataWidth-1];
      b_neg               = signed_op && req_operand_b[DataWidth-1];
      abs_a_in            = a_neg ? (~req_operand_a + 1'b1) : req_operand_a;
      abs_b_in            = b_neg ? (~req_operand_b + 1'b1) : req_operand_b;
      prod_low            = req_operand_a * req_operand_b;
      prep_ctl_in.valid   = req_valid;
      prep_ctl_in.op      = req_type;
      prep_ctl_in.quo_neg = (a_neg ^ b_neg) && (req_operand_b != '0);
      prep_ctl_in.rem_neg = a_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_pipe[0].valid <= 1'b0;
      end else if (en) begin
         ctl_pipe[0].valid <= prep_ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_pipe[0].op      <= prep_ctl_in.op;
         ctl_pipe[0].quo_neg <= prep_ctl_in.quo_neg;
         ctl_pipe[0].rem_neg <= prep_ctl_in.rem_neg;
         rem_pipe[0]         <= '0;
         quo_pipe[0]         <= abs_a_in;
         div_pipe[0]         <= abs_b_in;
         prod_pipe[0]        <= prod_low;
      end
   end

   for (genvar i = 0; i < Steps; i++) begin : g_step
      mdu_div_step u_step (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .ctl_in  (ctl_pipe[i]),
         .rem_in  (rem_pipe[i]),
         .quo_in  (quo_pipe[i]),
         .div_in  (div_pipe[i]),
         .prod_in (prod_pipe[i]),
         .ctl_ff  (ctl_pipe[i+1]),
         .rem_ff  (rem_pipe[i+1]),
         .quo_ff  (quo_pipe[i+1]),
         .div_ff  (div_pipe[i+1]),
         .prod_ff (prod_pipe[i+1])
      );
   end

   // result select and sign fix
   always_comb begin
      case (ctl_pipe[Steps].op) inside
         OP_MUL: begin
            final_result = prod_pipe[Steps];
         end
         OP_DIVU, OP_DIV: begin
            final_result = ctl_pipe[Steps].quo_neg ? (~quo_pipe[Steps] + 1'b1)
                                                   : quo_pipe[Steps];
         end
         OP_REMU, OP_REM: begin
            final_result = ctl_pipe[Steps].rem_neg ? (~rem_pipe[Steps] + 1'b1)
                                                   : rem_pipe[Steps];
         end
         default: begin
            final_result = '0;
         end
      endcase
   end

   // output word and skid
   assign push     = en && ctl_pipe[Steps].valid;
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_take) begin
         rsp_valid_ff  <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_take) begin
         rsp_result_ff <= skid_valid_ff ? skid_result_ff : final_result;
      end else if (push) begin
         skid_result_ff <= final_result;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   a_skid_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a word while output register is empty");

   a_skid_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid loaded without a stalled output word");

   a_frozen_pipe: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(ctl_pipe[Steps].valid) && $stable(quo_pipe[Steps]))
      else $error("pipeline moved while skid was full");

endmodule

>>> rtl/core/mdu_div_step.sv
// One restoring-division stage: retires one quotient bit per stage and
// carries the control word and product alongside. Depends on mdu_pkg.
module mdu_div_step import mdu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  pipe_ctl_type ctl_in,
   input  word_type     rem_in,
   input  word_type     quo_in,
   input  word_type     div_in,
   input  word_type     prod_in,
   output pipe_ctl_type ctl_ff,
   output word_type     rem_ff,
   output word_type     quo_ff,
   output word_type     div_ff,
   output word_type     prod_ff
);

   logic [DataWidth:0] trial;
   logic               fits;
   word_type           rem_in_next;
   word_type           quo_in_next;

   always_comb begin
      trial       = {rem_in, quo_in[DataWidth-1]} - {1'b0, div_in};
      fits        = !trial[DataWidth];
      rem_in_next = fits ? trial[DataWidth-1:0] : {rem_in[DataWidth-2:0], quo_in[DataWidth-1]};
      quo_in_next = {quo_in[DataWidth-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff.op      <= ctl_in.op;
         ctl_ff.quo_neg <= ctl_in.quo_neg;
         ctl_ff.rem_neg <= ctl_in.rem_neg;
         rem_ff         <= rem_in_next;
         quo_ff         <= quo_in_next;
         div_ff         <= div_in;
         prod_ff        <= prod_in;
      end
   end

endmodule

>>> test/tb_multiply_divide_unit_top.sv
// Testbench for multiply_divide_unit_top: directed table then random words,
// each result checked in order against its table value or an in-bench predictor.
// Depends on mdu_pkg and the multiply_divide_unit_top RTL.
`timescale 1ns / 100ps

module tb_multiply_divide_unit_top;
   import mdu_pkg::*;

   localparam mdu_op_type OP_MULH   = 3'd1;
   localparam mdu_op_type OP_MULHSU = 3'd2;
   localparam mdu_op_type OP_MULHU  = 3'd3;

   localparam word_type MIN_NEG  = 32'h8000_0000;
   localparam word_type MAX_POS  = 32'h7FFF_FFFF;
   localparam word_type ALL_ONES = 32'hFFFF_FFFF;

   localparam int LATENCY      = 33;
   localparam int MAX_GAP      = 18;
   localparam int RANDOM_WORDS = 1826;
   localparam int BURST_FROM   = 680;
   localparam int BURST_TO     = 1000;
   localparam int HOLD_AT      = 700;
   localparam int HOLD_CYCLES  = 250;
   localparam int PAUSE_AT     = 1300;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int REPORT_LIMIT = 10;
   localparam int TIMEOUT_NS   = 5_000_000;

   typedef struct packed {
      mdu_op_type op;
      word_type   a;
      word_type   b;
      word_type   want;
      logic       typed;
   } stim_row_type;

   typedef struct packed {
      mdu_op_type op;
      word_type   a;
      word_type   b;
      word_type   result;
   } pending_type;

   localparam int DIRECTED_ROWS = 24;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{OP_MUL,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1},
      '{OP_MUL,    ALL_ONES,      ALL_ONES,      32'h0000_0001, 1'b1},
      '{OP_MUL,    MIN_NEG,       32'h0000_0002, 32'h0000_0000, 1'b1},
      '{OP_MUL,    32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0000, 1'b0},
      '{OP_MULH,   ALL_ONES,      ALL_ONES,      32'h0000_0000, 1'b1},
      '{OP_MULHSU, MIN_NEG,       MAX_POS,       32'h0000_0000, 1'b1},
      '{OP_MULHU,  ALL_ONES,      32'h0000_0002, 32'h0000_0000, 1'b1},
      '{OP_DIVU,   32'h0000_0064, 32'h0000_0000, ALL_ONES,      1'b1},
      '{OP_DIV,    MIN_NEG,       32'h0000_0000, ALL_ONES,      1'b1},
      '{OP_REMU,   32'h0000_1234, 32'h0000_0000, 32'h0000_1234, 1'b1},
      '{OP_REM,    32'hFFFF_FFF0, 32'h0000_0000, 32'hFFFF_FFF0, 1'b1},
      '{OP_DIV,    MIN_NEG,       ALL_ONES,      MIN_NEG,       1'b1},
      '{OP_REM,    MIN_NEG,       ALL_ONES,      32'h0000_0000, 1'b1},
      '{OP_DIVU,   ALL_ONES,      32'h0000_0001, ALL_ONES,      1'b1},
      '{OP_DIVU,   ALL_ONES,      ALL_ONES,      32'h0000_0001, 1'b1},
      '{OP_REMU,   ALL_ONES,      32'h0000_0010, 32'h0000_0000, 1'b0},
      '{OP_DIV,    32'hFFFF_FFF9, 32'h0000_0002, 32'h0000_0000, 1'b0},
      '{OP_REM,    32'hFFFF_FFF9, 32'h0000_0002, 32'h0000_0000, 1'b0},
      '{OP_DIV,    32'h0000_0007, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0},
      '{OP_REM,    32'h0000_0007, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0},
      '{OP_DIV,    MAX_POS,       MIN_NEG,       32'h0000_0000, 1'b0},
      '{OP_REM,    MIN_NEG,       MIN_NEG,       32'h0000_0000, 1'b0},
      '{OP_DIVU,   32'h0000_0000, ALL_ONES,      32'h0000_0000, 1'b1},
      '{OP_DIV,    MIN_NEG,       32'h0000_0001, 32'h0000_0000, 1'b0}
   };

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_stall;
   mdu_op_type req_type      = OP_MUL;
   word_type   req_operand_a = '0;
   word_type   req_operand_b = '0;
   logic       rsp_valid;
   logic       rsp_stall     = 1'b0;
   word_type   rsp_result;

   pending_type pending_results[$];
   pending_type rsp_head;
   int          error_count = 0;

   multiply_divide_unit_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_result    (rsp_result)
   );

   always #4 clock = ~clock;

   function automatic word_type predict_result(input mdu_op_type op, input word_type a,
                                               input word_type b);
      logic     a_neg;
      logic     b_neg;
      word_type mag_a;
      word_type mag_b;
      word_type quo;
      word_type rem;
      a_neg = a[DataWidth-1];
      b_neg = b[DataWidth-1];
      mag_a = a_neg ? word_type'(-a) : a;
      mag_b = b_neg ? word_type'(-b) : b;
      quo   = (mag_b == '0) ? '0 : mag_a / mag_b;
      rem   = (mag_b == '0) ? '0 : mag_a % mag_b;
      case (op)
         OP_MUL:  return word_type'(a * b);
         OP_DIVU: return (b == '0) ? ALL_ONES : a / b;
         OP_REMU: return (b == '0) ? a : a % b;
         OP_DIV: begin
            if (b == '0) return ALL_ONES;
            if (a == MIN_NEG && b == ALL_ONES) return MIN_NEG;
            return (a_neg != b_neg) ? word_type'(-quo) : quo;
         end
         OP_REM: begin
            if (b == '0) return a;
            if (a == MIN_NEG && b == ALL_ONES) return '0;
            return a_neg ? word_type'(-rem) : rem;
         end
         default: return '0;
      endcase
   endfunction

   function automatic word_type random_operand();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 32'h0000_0001;
         2: return ALL_ONES;
         3: return MIN_NEG;
         4: return MAX_POS;
         5: return $urandom_range(0, 255);
         6: return 32'h0 - $urandom_range(1, 255);
         7: return $urandom >> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic note_failure(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
   endtask

   task automatic offer_word(input mdu_op_type op, input word_type a, input word_type b,
                             input word_type want, input logic typed, input int gap);
      pending_type entry;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_type      <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      entry.op     = op;
      entry.a      = a;
      entry.b      = b;
      entry.result = typed ? want : predict_result(op, a, b);
      pending_results.push_back(entry);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected word %h", rsp_result));
         end else begin
            rsp_head = pending_results.pop_front();
            if (rsp_result !== rsp_head.result)
               note_failure($sformatf("op %0d a %h b %h: expected %h, got %h",
                                      rsp_head.op, rsp_head.a, rsp_head.b,
                                      rsp_head.result, rsp_result));
         end
      end
   end

   // receiver: random stall before each word outside stall-free stretches, one long hold-off
   initial begin
      int   taken;
      int   wait_cycles;
      logic held;
      taken = 0;
      held  = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (!held && taken == HOLD_AT) begin
            held = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end
         wait_cycles = ((taken / 120) % 4 == 1) ? 0 : $urandom_range(0, MAX_GAP);
         repeat (wait_cycles) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   initial begin
      int         index;
      int         gap;
      int         drain;
      mdu_op_type op;
      word_type   a;
      word_type   b;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      for (index = 0; index < DIRECTED_ROWS + RANDOM_WORDS; index++) begin
         if (index == PAUSE_AT) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         if ((index >= BURST_FROM && index < BURST_TO) || ((index / 150) % 4 == 2))
            gap = 0;
         else
            gap = $urandom_range(0, MAX_GAP);
         if (index < DIRECTED_ROWS) begin
            offer_word(DIRECTED[index].op, DIRECTED[index].a, DIRECTED[index].b,
                       DIRECTED[index].want, DIRECTED[index].typed, gap);
         end else begin
            op = mdu_op_type'($urandom_range(0, 7));
            a  = random_operand();
            b  = random_operand();
            if ($urandom_range(0, 31) == 0) begin
               a = MIN_NEG;
               b = ALL_ONES;
            end
            offer_word(op, a, b, '0, 1'b0, gap);
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;
      drain = 0;
      while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (LATENCY + 8) @(posedge clock);
      if (pending_results.size() != 0)
         note_failure($sformatf("%0d words never returned", pending_results.size()));
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("status: fail");
      $finish;
   end

endmodule

>>> files.f
rtl/core/mdu_pkg.sv
rtl/core/mdu_div_step.sv
rtl/core/multiply_divide_unit_top.sv
test/tb_multiply_divide_unit_top.sv
